FILE: hdl/ray_triangle_intersect_defines.svh
// Assertion macros shared by the ray / triangle intersection block.
`ifndef RAY_TRIANGLE_INTERSECT_DEFINES_SVH
`define RAY_TRIANGLE_INTERSECT_DEFINES_SVH

// Condition must never be true at a clock edge outside reset.
`define RTI_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define RTI_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

FILE: hdl/rti_pkg.sv
// Shared types, widths and constants of the ray / triangle intersection block.
`timescale 1ns / 1ps
package rti_pkg;

  localparam int CW    = 32;       // Q16.16 coordinate
  localparam int EW    = CW + 1;   // edge / offset vector component
  localparam int NRMW  = 2*EW + 1; // normal component
  localparam int DAOW  = EW + CW + 1;
  localparam int DW    = 104;      // det and numerators, exact
  localparam int FRAC  = 16;
  localparam int NW    = DW + FRAC; // scaled numerator
  localparam int QB    = 32;        // quotient bits below the saturation bit
  localparam int SW    = DW + QB;   // divider compare width
  localparam int MDW   = 40;
  localparam int CFG_IDX_W = 3;
  localparam int QUEUE_DEPTH_DEF = 4;

  localparam logic [MDW-1:0] MIN_DET_RST = 40'd281474977;
  localparam logic [CW-1:0]  DIST_MAX    = 32'h7FFF_FFFF;
  localparam logic [CW-1:0]  DIST_MIN    = 32'h8000_0000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ORG_X   = 3'd0,
    REG_ORG_Y   = 3'd1,
    REG_ORG_Z   = 3'd2,
    REG_DIR_X   = 3'd3,
    REG_DIR_Y   = 3'd4,
    REG_DIR_Z   = 3'd5,
    REG_MIN_DET = 3'd6
  } rti_reg_t;

  typedef struct packed {
    logic signed [CW-1:0] org_x;
    logic signed [CW-1:0] org_y;
    logic signed [CW-1:0] org_z;
    logic signed [CW-1:0] dir_x;
    logic signed [CW-1:0] dir_y;
    logic signed [CW-1:0] dir_z;
    logic [MDW-1:0]       min_det;
  } rti_ray_t;

  typedef struct packed {
    logic signed [CW-1:0] a_x;
    logic signed [CW-1:0] a_y;
    logic signed [CW-1:0] a_z;
    logic signed [CW-1:0] b_x;
    logic signed [CW-1:0] b_y;
    logic signed [CW-1:0] b_z;
    logic signed [CW-1:0] c_x;
    logic signed [CW-1:0] c_y;
    logic signed [CW-1:0] c_z;
  } rti_tgl_t;

  // One classified triangle waiting for its distance.
  typedef struct packed {
    logic          hit;
    logic          neg;
    logic          dzero;
    logic [NW-1:0] num;  // |tnum| << 16
    logic [DW-1:0] den;  // |det|
  } rti_job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } rti_qstat_t;

endpackage

FILE: hdl/rti_wmul.sv
// Two-stage signed multiplier, wide operand split into a low word and a high part.
`timescale 1ns / 1ps
module rti_wmul #(
  parameter int AW = 33,
  parameter int BW = 67
) (
  input  logic                    clk,
  input  logic                    en,
  input  logic signed [AW-1:0]    a,
  input  logic signed [BW-1:0]    b,
  output logic signed [AW+BW-1:0] p
);

  localparam int LW  = 32;
  localparam int HW  = BW - LW;
  localparam int PLW = AW + LW + 1;
  localparam int PHW = AW + HW;
  localparam int PW  = AW + BW;

  logic signed [PLW-1:0] plo_r;
  logic signed [PHW-1:0] phi_r;
  logic signed [PW-1:0]  p_r;

  always_ff @(posedge clk) begin
    if (en) begin
      plo_r <= a * $signed({1'b0, b[LW-1:0]});
      phi_r <= a * $signed(b[BW-1:LW]);
      p_r   <= (PW'(phi_r) <<< LW) + PW'(plo_r);
    end
  end

  assign p = p_r;

endmodule

FILE: hdl/rti_front.sv
// Front end: edges, normal, cross products, dot products and hit classification.
`timescale 1ns / 1ps
module rti_front import rti_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  rti_tgl_t   tgl,
  input  rti_ray_t   ray,
  input  rti_qstat_t q_stat,
  output logic       push,
  output rti_job_t   job
);

  localparam int FST = 8; // stages up to the queue

  logic [FST:1] v_r;
  logic         fe;

  logic signed [CW-1:0]   org [3];
  logic signed [CW-1:0]   dir [3];

  logic signed [EW-1:0]   e1_r [3], e2_r [3], ao_r [3];
  logic signed [EW-1:0]   e1_2_r [3], e2_2_r [3], ao_2_r [3];
  logic signed [EW-1:0]   e1_3_r [3], e2_3_r [3], ao_3_r [3];
  logic signed [2*EW-1:0] np_r [6];
  logic signed [EW+CW-1:0] dp_r [6];
  logic signed [NRMW-1:0] nrm_r [3];
  logic signed [DAOW-1:0] dao_r [3];

  logic signed [CW+NRMW-1:0] pd [3];
  logic signed [EW+DAOW-1:0] pu [3];
  logic signed [EW+DAOW-1:0] pv [3];
  logic signed [EW+NRMW-1:0] pt [3];

  logic signed [DW-1:0] det_r, unum_r, vnum_r, tnum_r;
  logic signed [DW-1:0] det7_r, suv_r;
  logic [DW-1:0]        tabs_r, dabs_r;
  logic                 ge_r, nz_r, pos_r, neg_r;
  rti_job_t             job_r;

  assign fe       = !v_r[FST] || !q_stat.full;
  assign in_ready = fe;
  assign push     = v_r[FST] && !q_stat.full;
  assign job      = job_r;

  assign org[0] = ray.org_x;
  assign org[1] = ray.org_y;
  assign org[2] = ray.org_z;
  assign dir[0] = ray.dir_x;
  assign dir[1] = ray.dir_y;
  assign dir[2] = ray.dir_z;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (fe) begin
      v_r <= {v_r[FST-1:1], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (fe) begin
      // edges and origin offset
      e1_r[0] <= EW'($signed(tgl.b_x)) - EW'($signed(tgl.a_x));
      e1_r[1] <= EW'($signed(tgl.b_y)) - EW'($signed(tgl.a_y));
      e1_r[2] <= EW'($signed(tgl.b_z)) - EW'($signed(tgl.a_z));
      e2_r[0] <= EW'($signed(tgl.c_x)) - EW'($signed(tgl.a_x));
      e2_r[1] <= EW'($signed(tgl.c_y)) - EW'($signed(tgl.a_y));
      e2_r[2] <= EW'($signed(tgl.c_z)) - EW'($signed(tgl.a_z));
      ao_r[0] <= EW'(org[0]) - EW'($signed(tgl.a_x));
      ao_r[1] <= EW'(org[1]) - EW'($signed(tgl.a_y));
      ao_r[2] <= EW'(org[2]) - EW'($signed(tgl.a_z));
      // cross product terms
      np_r[0] <= e1_r[1] * e2_r[2];
      np_r[1] <= e1_r[2] * e2_r[1];
      np_r[2] <= e1_r[2] * e2_r[0];
      np_r[3] <= e1_r[0] * e2_r[2];
      np_r[4] <= e1_r[0] * e2_r[1];
      np_r[5] <= e1_r[1] * e2_r[0];
      dp_r[0] <= ao_r[1] * dir[2];
      dp_r[1] <= ao_r[2] * dir[1];
      dp_r[2] <= ao_r[2] * dir[0];
      dp_r[3] <= ao_r[0] * dir[2];
      dp_r[4] <= ao_r[0] * dir[1];
      dp_r[5] <= ao_r[1] * dir[0];
      for (int i = 0; i < 3; i++) begin
        e1_2_r[i] <= e1_r[i];
        e2_2_r[i] <= e2_r[i];
        ao_2_r[i] <= ao_r[i];
        e1_3_r[i] <= e1_2_r[i];
        e2_3_r[i] <= e2_2_r[i];
        ao_3_r[i] <= ao_2_r[i];
        nrm_r[i]  <= NRMW'(np_r[2*i]) - NRMW'(np_r[2*i+1]);
        dao_r[i]  <= DAOW'(dp_r[2*i]) - DAOW'(dp_r[2*i+1]);
      end
      // dot product sums
      det_r  <= DW'(0) - (DW'(pd[0]) + DW'(pd[1]) + DW'(pd[2]));
      unum_r <= DW'(pu[0]) + DW'(pu[1]) + DW'(pu[2]);
      vnum_r <= DW'(0) - (DW'(pv[0]) + DW'(pv[1]) + DW'(pv[2]));
      tnum_r <= DW'(pt[0]) + DW'(pt[1]) + DW'(pt[2]);
      // classification, first half
      suv_r  <= unum_r + vnum_r;
      det7_r <= det_r;
      ge_r   <= det_r >= $signed({{(DW-MDW){1'b0}}, ray.min_det});
      nz_r   <= det_r != '0;
      pos_r  <= !tnum_r[DW-1] && !unum_r[DW-1] && !vnum_r[DW-1];
      neg_r  <= tnum_r[DW-1] ^ det_r[DW-1];
      tabs_r <= tnum_r[DW-1] ? DW'(-tnum_r) : DW'(tnum_r);
      dabs_r <= det_r[DW-1] ? DW'(-det_r) : DW'(det_r);
      // classification, second half
      job_r.hit   <= ge_r && nz_r && pos_r && (suv_r <= det7_r);
      job_r.neg   <= neg_r;
      job_r.dzero <= !nz_r;
      job_r.num   <= {tabs_r, {FRAC{1'b0}}};
      job_r.den   <= dabs_r;
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_dot
    rti_wmul #(.AW(CW), .BW(NRMW)) u_md (
      .clk(clk), .en(fe), .a(dir[i]), .b(nrm_r[i]), .p(pd[i]));
    rti_wmul #(.AW(EW), .BW(DAOW)) u_mu (
      .clk(clk), .en(fe), .a(e2_3_r[i]), .b(dao_r[i]), .p(pu[i]));
    rti_wmul #(.AW(EW), .BW(DAOW)) u_mv (
      .clk(clk), .en(fe), .a(e1_3_r[i]), .b(dao_r[i]), .p(pv[i]));
    rti_wmul #(.AW(EW), .BW(NRMW)) u_mt (
      .clk(clk), .en(fe), .a(ao_3_r[i]), .b(nrm_r[i]), .p(pt[i]));
  end

endmodule

FILE: hdl/rti_queue.sv
// Short queue between front and back ends.
`timescale 1ns / 1ps
module rti_queue import rti_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  rti_job_t   wdata,
  input  logic       pop,
  output rti_job_t   rdata,
  output rti_qstat_t stat
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNW = $clog2(DEPTH + 1);

  rti_job_t       mem_r [DEPTH];
  logic [PW-1:0]  wr_ptr_r, rd_ptr_r;
  logic [CNW-1:0] cnt_r;

  function automatic logic [PW-1:0] wrap_inc(input logic [PW-1:0] p);
    return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= wrap_inc(wr_ptr_r);
      if (pop)  rd_ptr_r <= wrap_inc(rd_ptr_r);
      if (push && !pop)      cnt_r <= cnt_r + 1'b1;
      else if (pop && !push) cnt_r <= cnt_r - 1'b1;
    end
  end

  assign rdata      = mem_r[rd_ptr_r];
  assign stat.full  = cnt_r == CNW'(DEPTH);
  assign stat.empty = cnt_r == '0;

endmodule

FILE: hdl/rti_back.sv
// Back end: pipelined restoring divider for the distance, and the output register.
`timescale 1ns / 1ps
module rti_back import rti_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  rti_job_t          job,
  input  rti_qstat_t        q_stat,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              out_hit,
  output logic signed [CW-1:0] out_distance
);

  logic            be;
  logic [QB:0]     vld_r;
  logic [NW-1:0]   rem_r [QB];
  logic [DW-1:0]   den_r [QB];
  logic [QB-1:0]   q_r   [QB+1];
  logic [QB:0]     sat_r, hit_r, neg_r, dz_r;

  logic            out_valid_r, out_hit_r;
  logic [CW-1:0]   out_dist_r;
  logic [CW-1:0]   dist_nxt;

  assign be  = !out_valid_r || out_ready;
  assign pop = be && !q_stat.empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (be) begin
      vld_r       <= {vld_r[QB-1:0], pop};
      out_valid_r <= vld_r[QB];
    end
  end

  // stage 0: saturation check, quotient of 2^32 or more
  always_ff @(posedge clk) begin
    if (be) begin
      rem_r[0] <= job.num;
      den_r[0] <= job.den;
      q_r[0]   <= '0;
      sat_r[0] <= SW'(job.num) >= {job.den, {QB{1'b0}}};
      hit_r[0] <= job.hit;
      neg_r[0] <= job.neg;
      dz_r[0]  <= job.dzero;
    end
  end

  // one quotient bit a stage, msb first
  for (genvar k = 0; k < QB; k++) begin : g_div
    localparam int B = QB - 1 - k;
    logic [SW-1:0] dsh;
    logic          ge;
    assign dsh = SW'(den_r[k]) << B;
    assign ge  = SW'(rem_r[k]) >= dsh;
    always_ff @(posedge clk) begin
      if (be) begin
        q_r[k+1]   <= q_r[k] | (ge ? (QB'(1) << B) : QB'(0));
        sat_r[k+1] <= sat_r[k];
        hit_r[k+1] <= hit_r[k];
        neg_r[k+1] <= neg_r[k];
        dz_r[k+1]  <= dz_r[k];
      end
    end
    if (k < QB - 1) begin : g_rem
      always_ff @(posedge clk) begin
        if (be) begin
          rem_r[k+1] <= ge ? rem_r[k] - dsh[NW-1:0] : rem_r[k];
          den_r[k+1] <= den_r[k];
        end
      end
    end
  end

  // signed saturation of the magnitude; a zero determinant gives the maximum
  always_comb begin
    if (dz_r[QB]) begin
      dist_nxt = DIST_MAX;
    end else if (neg_r[QB]) begin
      dist_nxt = (sat_r[QB] || q_r[QB][QB-1]) ? DIST_MIN : CW'(-q_r[QB]);
    end else begin
      dist_nxt = (sat_r[QB] || q_r[QB][QB-1]) ? DIST_MAX : q_r[QB];
    end
  end

  always_ff @(posedge clk) begin
    if (be) begin
      out_hit_r  <= hit_r[QB];
      out_dist_r <= dist_nxt;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_hit      = out_hit_r;
  assign out_distance = $signed(out_dist_r);

endmodule

FILE: hdl/ray_triangle_intersect.sv
// Top level of the ray / triangle intersection block.
`timescale 1ns / 1ps
`include "ray_triangle_intersect_defines.svh"
// Ray / triangle intersection, back faces culled, exact fixed point. The ray
// (origin, direction, min_det) sits in configuration registers; each input beat
// is one triangle and gives exactly one output beat with hit and distance
// (Q16.16, quotient rounded toward zero, saturated; 0x7FFFFFFF for a zero
// determinant). Throughput is one triangle per cycle when nothing stalls. On
// its way from input beat to output beat a triangle passes 8 front stages
// (edges, cross products, split-word dot products, classification), the queue,
// 33 divider stages (saturation check then one quotient bit each) and the
// output register. The front and back ends stall independently; the queue
// between them holds QUEUE_DEPTH beats, and in_ready drops only when the
// queue is full and the front's last stage holds a beat. Configuration
// writes are always taken (cfg_ready is tied high); an index beyond the list
// is ignored. Write the configuration only while the block is idle.
module ray_triangle_intersect import rti_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // configuration
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [MDW-1:0]       cfg_data,
  // triangle beats
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic signed [CW-1:0] in_vert_a_x,
  input  logic signed [CW-1:0] in_vert_a_y,
  input  logic signed [CW-1:0] in_vert_a_z,
  input  logic signed [CW-1:0] in_vert_b_x,
  input  logic signed [CW-1:0] in_vert_b_y,
  input  logic signed [CW-1:0] in_vert_b_z,
  input  logic signed [CW-1:0] in_vert_c_x,
  input  logic signed [CW-1:0] in_vert_c_y,
  input  logic signed [CW-1:0] in_vert_c_z,
  // result beats
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 out_hit,
  output logic signed [CW-1:0] out_distance
);

  rti_ray_t   ray_r;
  rti_tgl_t   tgl;
  rti_job_t   push_job, pop_job;
  rti_qstat_t q_stat;
  logic       q_push, q_pop;

  assign cfg_ready = 1'b1;

  // register file; writes beyond the list fall through
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ray_r.org_x   <= '0;
      ray_r.org_y   <= '0;
      ray_r.org_z   <= '0;
      ray_r.dir_x   <= '0;
      ray_r.dir_y   <= '0;
      ray_r.dir_z   <= '0;
      ray_r.min_det <= MIN_DET_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_ORG_X:   ray_r.org_x   <= $signed(cfg_data[CW-1:0]);
        REG_ORG_Y:   ray_r.org_y   <= $signed(cfg_data[CW-1:0]);
        REG_ORG_Z:   ray_r.org_z   <= $signed(cfg_data[CW-1:0]);
        REG_DIR_X:   ray_r.dir_x   <= $signed(cfg_data[CW-1:0]);
        REG_DIR_Y:   ray_r.dir_y   <= $signed(cfg_data[CW-1:0]);
        REG_DIR_Z:   ray_r.dir_z   <= $signed(cfg_data[CW-1:0]);
        REG_MIN_DET: ray_r.min_det <= cfg_data;
        default: ;
      endcase
    end
  end

  assign tgl.a_x = in_vert_a_x;
  assign tgl.a_y = in_vert_a_y;
  assign tgl.a_z = in_vert_a_z;
  assign tgl.b_x = in_vert_b_x;
  assign tgl.b_y = in_vert_b_y;
  assign tgl.b_z = in_vert_b_z;
  assign tgl.c_x = in_vert_c_x;
  assign tgl.c_y = in_vert_c_y;
  assign tgl.c_z = in_vert_c_z;

  rti_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .tgl      (tgl),
    .ray      (ray_r),
    .q_stat   (q_stat),
    .push     (q_push),
    .job      (push_job)
  );

  rti_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (push_job),
    .pop   (q_pop),
    .rdata (pop_job),
    .stat  (q_stat)
  );

  rti_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .job          (pop_job),
    .q_stat       (q_stat),
    .pop          (q_pop),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_hit      (out_hit),
    .out_distance (out_distance)
  );

  // queue must never be written full or read empty
  `RTI_ASSERT_NEVER(a_q_overflow, q_push && q_stat.full, "queue push while full")
  `RTI_ASSERT_NEVER(a_q_underflow, q_pop && q_stat.empty, "queue pop while empty")
  // a front-face hit has det > 0 and t >= 0, so the distance is non-negative
  `RTI_ASSERT_IMP(a_hit_dist, out_valid && out_hit, !out_distance[31], "hit with negative t")

endmodule

FILE: verif/testbench.sv
// Self-checking testbench for the ray / triangle intersection block.
`timescale 1ns / 1ps
module testbench;
  import rti_pkg::*;

  // Expected hit/distance pairs, oldest first, plus the predictor itself.
  class hit_scoreboard;
    logic signed [31:0] org[3];
    logic signed [31:0] dir[3];
    logic [39:0] min_det;
    logic expected_hit[$];
    logic [31:0] expected_dist[$];
    int errors;
    int hits;

    function void apply_reg(rti_reg_t idx, logic [39:0] val);
      case (idx)
        REG_ORG_X: org[0] = val[31:0];
        REG_ORG_Y: org[1] = val[31:0];
        REG_ORG_Z: org[2] = val[31:0];
        REG_DIR_X: dir[0] = val[31:0];
        REG_DIR_Y: dir[1] = val[31:0];
        REG_DIR_Z: dir[2] = val[31:0];
        REG_MIN_DET: min_det = val;
        default: ;
      endcase
    endfunction

    function void note_triangle(logic signed [31:0] v[9]);
      logic signed [127:0] e1[3], e2[3], ao[3], n[3], dao[3], o[3], d[3];
      logic signed [127:0] det, unum, vnum, tnum, num, den, q;
      logic [31:0] dist_val;
      logic h;
      for (int i = 0; i < 3; i++) begin
        o[i] = org[i];
        d[i] = dir[i];
        e1[i] = 128'(v[3+i]) - 128'(v[i]);
        e2[i] = 128'(v[6+i]) - 128'(v[i]);
        ao[i] = o[i] - 128'(v[i]);
      end
      n[0] = e1[1]*e2[2] - e1[2]*e2[1];
      n[1] = e1[2]*e2[0] - e1[0]*e2[2];
      n[2] = e1[0]*e2[1] - e1[1]*e2[0];
      dao[0] = ao[1]*d[2] - ao[2]*d[1];
      dao[1] = ao[2]*d[0] - ao[0]*d[2];
      dao[2] = ao[0]*d[1] - ao[1]*d[0];
      det = -(d[0]*n[0] + d[1]*n[1] + d[2]*n[2]);
      unum = e2[0]*dao[0] + e2[1]*dao[1] + e2[2]*dao[2];
      vnum = -(e1[0]*dao[0] + e1[1]*dao[1] + e1[2]*dao[2]);
      tnum = ao[0]*n[0] + ao[1]*n[1] + ao[2]*n[2];
      h = det >= $signed({88'd0, min_det}) && det != 0 && tnum >= 0 && unum >= 0
          && vnum >= 0 && unum + vnum <= det;
      if (det == 0) begin
        dist_val = DIST_MAX;
      end else begin
        num = (tnum < 0 ? -tnum : tnum) <<< 16;
        den = det < 0 ? -det : det;
        q = $signed($unsigned(num) / $unsigned(den));
        if ((tnum < 0) != (det < 0)) dist_val = q >= 128'sh80000000 ? DIST_MIN : 32'(-q);
        else dist_val = q > 128'sh7FFFFFFF ? DIST_MAX : q[31:0];
      end
      expected_hit.push_back(h);
      expected_dist.push_back(dist_val);
    endfunction

    function void check_result(logic h, logic [31:0] dist_val);
      logic eh;
      logic [31:0] ed;
      if (expected_hit.size() == 0) begin
        $display("%0t: result beat with nothing expected (hit %0b dist %h)", $time, h,
                 dist_val);
        errors++;
        return;
      end
      eh = expected_hit.pop_front();
      ed = expected_dist.pop_front();
      if (h) hits++;
      if (eh !== h) begin
        $display("%0t: hit expected %0b actual %0b", $time, eh, h);
        errors++;
      end
      if (ed !== dist_val) begin
        $display("%0t: distance expected %h actual %h", $time, ed, dist_val);
        errors++;
      end
    endfunction
  endclass

  logic clk, rst_n;
  logic cfg_valid, cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [MDW-1:0] cfg_data;
  logic in_valid, in_ready;
  logic signed [CW-1:0] vin[9];
  logic out_valid, out_ready, out_hit;
  logic signed [CW-1:0] out_distance;

  ray_triangle_intersect dut (
    .clk, .rst_n, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .in_valid, .in_ready,
    .in_vert_a_x(vin[0]), .in_vert_a_y(vin[1]), .in_vert_a_z(vin[2]),
    .in_vert_b_x(vin[3]), .in_vert_b_y(vin[4]), .in_vert_b_z(vin[5]),
    .in_vert_c_x(vin[6]), .in_vert_c_y(vin[7]), .in_vert_c_z(vin[8]),
    .out_valid, .out_ready, .out_hit, .out_distance
  );

  hit_scoreboard sb;
  int send_idle_pct, recv_idle_pct;
  int cycles;
  int triangles_sent;
  int cfg_writes;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Watchdog: 1665 beats, stalls up to 3/4 of cycles.
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > 200000) begin
        $display("testbench: errors");
        $finish;
      end
    end
  end

  // Receiver: random back-pressure, checks every accepted result beat.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_result(out_hit, out_distance);
    out_ready <= !rst_n ? 1'b0 : ($urandom_range(99) >= recv_idle_pct);
  end

  // Valid stays up after the beat; the next send drops it.
  task automatic write_reg(rti_reg_t idx, logic [39:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    sb.apply_reg(idx, val);
    cfg_writes++;
  endtask

  // Out-of-range index: the block must ignore it.
  task automatic write_bad_index();
    cfg_valid <= 1'b1;
    cfg_index <= CFG_IDX_W'(7);
    cfg_data <= 40'({$urandom, $urandom});
    do @(posedge clk); while (!cfg_ready);
  endtask

  // in_valid stays up after the beat unless an idle cycle or a drain follows.
  task automatic send_triangle(logic signed [31:0] v[9]);
    cfg_valid <= 1'b0;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    for (int i = 0; i < 9; i++) vin[i] <= v[i];
    do @(posedge clk); while (!in_ready);
    sb.note_triangle(v);
    triangles_sent++;
  endtask

  // Drain all outstanding beats, then allow for the pipeline depth.
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.expected_hit.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_coord(int mode);
    case (mode)
      0: return $urandom;
      1: return $signed($urandom_range(65536 * 16)) - 32'sd524288;
      2: return $urandom_range(1) ? 32'h7FFFFFFF : 32'h80000000;
      default: return $signed($urandom_range(2048)) - 32'sd1024;
    endcase
  endfunction

  // Random ray: mode 0 full range, 1 and 3 modest so hits happen, 2 extreme values.
  task automatic program_ray(int mode);
    write_reg(REG_ORG_X, rand_coord(mode));
    write_reg(REG_ORG_Y, rand_coord(mode));
    write_reg(REG_ORG_Z, rand_coord(mode));
    write_reg(REG_DIR_X, rand_coord(mode));
    write_reg(REG_DIR_Y, rand_coord(mode));
    write_reg(REG_DIR_Z, rand_coord(mode));
    case ($urandom_range(3))
      0: write_reg(REG_MIN_DET, 40'd0);
      1: write_reg(REG_MIN_DET, 40'hFF_FFFF_FFFF);
      2: write_reg(REG_MIN_DET, MIN_DET_RST);
      default: write_reg(REG_MIN_DET, 40'({$urandom, $urandom}));
    endcase
  endtask

  // Triangle built around the ray's aim point so that many beats hit.
  task automatic aimed_triangle();
    logic signed [31:0] v[9];
    logic signed [63:0] p;
    int s;
    s = $urandom_range(3) == 0 ? 0 : $urandom_range(6, 1);
    for (int i = 0; i < 3; i++) begin
      p = 64'(sb.org[i]) + 64'(sb.dir[i]) * $urandom_range(4, 1);
      for (int k = 0; k < 3; k++)
        v[3*k+i] = 32'(p + ($signed($urandom_range(65536 << s)) - (32768 << s)));
    end
    send_triangle(v);
  endtask

  initial begin
    logic signed [31:0] v[9];
    sb = new();
    foreach (sb.org[i]) begin
      sb.org[i] = 0;
      sb.dir[i] = 0;
    end
    sb.min_det = MIN_DET_RST;
    send_idle_pct = 10;
    recv_idle_pct = 76;
    triangles_sent = 0;
    cfg_writes = 0;
    rst_n = 0;
    cfg_valid = 0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 0;
    foreach (vin[i]) vin[i] = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset ray: zero direction gives a zero determinant.
    for (int i = 0; i < 9; i++) v[i] = i * 32'sh10000;
    send_triangle(v);
    drain();

    // Directed: unit ray down -z onto a front-facing triangle in z=0.
    write_reg(REG_ORG_X, 32'sh4000);
    write_reg(REG_ORG_Y, 32'sh4000);
    write_reg(REG_ORG_Z, 32'sh50000);
    write_reg(REG_DIR_X, 0);
    write_reg(REG_DIR_Y, 0);
    write_reg(REG_DIR_Z, -32'sh10000);
    write_reg(REG_MIN_DET, 40'd0);
    v = '{0, 0, 0, 32'sh10000, 0, 0, 0, 32'sh10000, 0};
    send_triangle(v);                       // front face hit
    v = '{0, 0, 0, 0, 32'sh10000, 0, 32'sh10000, 0, 0};
    send_triangle(v);                       // back face: negative determinant
    v = '{0, 0, 0, 32'sh10000, 32'sh10000, 0, 32'sh20000, 32'sh20000, 0};
    send_triangle(v);                       // degenerate: zero determinant
    v = '{0, 0, 32'sh60000, 32'sh10000, 0, 32'sh60000, 0, 32'sh10000, 32'sh60000};
    send_triangle(v);                       // behind origin: negative t
    v = '{32'sh10000, 0, 0, 32'sh20000, 0, 0, 32'sh10000, 32'sh10000, 0};
    send_triangle(v);                       // outside: u/v fails
    v = '{0, 0, 0, 32'sh1, 0, 0, 0, 32'sh1, 0};
    send_triangle(v);                       // tiny triangle: misses, u/v fails
    for (int i = 0; i < 9; i++) v[i] = 32'h7FFFFFFF;
    send_triangle(v);
    for (int i = 0; i < 9; i++) v[i] = 32'h80000000;
    send_triangle(v);
    v = '{32'h80000000, 32'h7FFFFFFF, 0, 32'h7FFFFFFF, 32'h80000000, 32'h80000000,
          32'h80000000, 32'h80000000, 32'h7FFFFFFF};
    send_triangle(v);
    drain();
    write_bad_index();
    write_reg(REG_MIN_DET, 40'hFF_FFFF_FFFF);  // front hit still clears min_det
    v = '{0, 0, 0, 32'sh10000, 0, 0, 0, 32'sh10000, 0};
    send_triangle(v);
    drain();
    write_reg(REG_ORG_X, 32'h80000000);
    write_reg(REG_ORG_Y, 32'h7FFFFFFF);
    write_reg(REG_ORG_Z, 32'h80000000);
    write_reg(REG_DIR_X, 32'h7FFFFFFF);
    write_reg(REG_DIR_Y, 32'h80000000);
    write_reg(REG_DIR_Z, 32'h7FFFFFFF);
    write_reg(REG_MIN_DET, 40'd0);
    for (int k = 0; k < 4; k++) begin
      for (int i = 0; i < 9; i++) v[i] = rand_coord(k == 0 ? 2 : 0);
      send_triangle(v);
    end
    drain();

    // Random phases: three idle schemes, several rays each.
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = ph == 0 ? 10 : (ph == 1 ? 76 : 0);
      recv_idle_pct = ph == 0 ? 76 : (ph == 1 ? 10 : 0);
      for (int r = 0; r < 10; r++) begin
        program_ray(r % 4);
        if (r == 5) write_bad_index();
        for (int k = 0; k < 55; k++) begin
          if ($urandom_range(9) < 7) begin
            aimed_triangle();
          end else begin
            for (int i = 0; i < 9; i++) v[i] = rand_coord($urandom_range(3));
            send_triangle(v);
          end
        end
        drain();
      end
    end

    $display("Sent %0d triangles over %0d register writes; %0d hits seen.",
             triangles_sent, cfg_writes, sb.hits);
    $display("Covered culling, zero determinant, saturation and three stall mixes.");
    if (sb.errors == 0 && sb.expected_hit.size() == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end
endmodule
